FILE: rtl/core/lss_pkg.sv
// Package for the LIFO stack with search: sizes, request kinds,
// request/result payload structs and controller/datapath link structs.
// No dependencies.
package lss_pkg;

	localparam int DEPTH  = 16;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int VAL_W  = 32;
	localparam int DIST_W = 4;

	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [VAL_W-1:0] value;
	} lss_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped_value;
		logic                    underflow;
		logic                    overflow;
		logic                    found;
		logic [DIST_W-1:0]       distance;
		logic signed [VAL_W-1:0] top_value;
		logic                    is_empty;
	} lss_res_t;

	typedef struct packed {
		logic take_push;
		logic take_pop;
		logic take_srch;
		logic take_nop;
		logic pop_fin;
		logic srch_step;
	} lss_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic match;
		logic last;
	} lss_sts_t;

endpackage

FILE: rtl/core/lifo_stack_with_search.sv
// LIFO stack of signed 32-bit words with push, pop and search from the top.
// Results come one cycle wide on rsp, marked by done, and cannot be stalled.
// For a push, a pop on an empty stack, a search of an empty stack and the
// unused kind, the result strobe follows the accepting edge. A pop passes
// through ST_POP, which loads the new top word read from the memory. A
// search steps through the held entries one at a time: the single memory
// read port delivers one entry per cycle from the top down, stopping at the
// first match. busy is high while a pop or search is in progress; a new
// request may be issued in the same cycle that done is high.
// Depends on lss_pkg, lss_ctrl, lss_dp.
module lifo_stack_with_search
	import lss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  lss_req_t req,
	output logic     busy,
	output logic     done,
	output lss_res_t rsp
);

	lss_cmd_t cmd;
	lss_sts_t sts;

	lss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lss_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (req.value),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: rtl/core/lss_ctrl.sv
// Controller FSM for the LIFO stack with search: accepts requests,
// sequences pop and search through the datapath, drives the result strobe.
// Depends on lss_pkg.
module lss_ctrl
	import lss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  lss_sts_t   sts,
	output lss_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;
	logic       take;

	assign busy = (state_q != ST_IDLE);
	assign take = start && !busy;
	assign done = done_q;

	always_comb begin
		cmd           = '0;
		cmd.take_push = take && (kind == KIND_PUSH);
		cmd.take_pop  = take && (kind == KIND_POP);
		cmd.take_srch = take && (kind == KIND_SEARCH);
		cmd.take_nop  = take && (kind != KIND_PUSH) && (kind != KIND_POP)
		                && (kind != KIND_SEARCH);
		cmd.pop_fin   = (state_q == ST_POP);
		cmd.srch_step = (state_q == ST_SRCH);
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (cmd.take_pop && !sts.empty) begin
						state_d = ST_POP;
					end else if (cmd.take_srch && !sts.empty) begin
						state_d = ST_SRCH;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_POP: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SRCH: begin
				if (sts.match || sts.last) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

endmodule

FILE: rtl/core/lss_dp.sv
// Datapath for the LIFO stack with search: entry memory, count, top word,
// search pointer and key, and the result register.
// Depends on lss_pkg.
module lss_dp
	import lss_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lss_cmd_t                cmd,
	input  logic signed [VAL_W-1:0] value,
	output lss_sts_t                sts,
	output lss_res_t                rsp
);

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;
	logic [AW-1:0]           rd_addr;

	logic [CW-1:0]           count_q;
	logic signed [VAL_W-1:0] top_q;
	logic signed [VAL_W-1:0] key_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           dist_q;
	lss_res_t                res_q;
	lss_res_t                res_d;
	logic                    res_ld;

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(DEPTH));
	assign sts.match = (rd_data_q == key_q);
	assign sts.last  = (CW'(dist_q) == (count_q - CW'(1)));
	assign rsp       = res_q;

	always_comb begin
		priority if (cmd.take_pop) begin
			rd_addr = AW'(count_q - CW'(2));
		end else if (cmd.srch_step) begin
			rd_addr = ptr_q - AW'(1);
		end else begin
			rd_addr = AW'(count_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_push && !sts.full) begin
			mem[count_q[AW-1:0]] <= value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take_push && !sts.full) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.take_pop && !sts.empty) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_push && !sts.full) begin
			top_q <= value;
		end else if (cmd.pop_fin) begin
			top_q <= rd_data_q;
		end
		if (cmd.take_srch) begin
			key_q  <= value;
			ptr_q  <= AW'(count_q - CW'(1));
			dist_q <= '0;
		end else if (cmd.srch_step) begin
			ptr_q  <= ptr_q - AW'(1);
			dist_q <= dist_q + AW'(1);
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		res_d           = '0;
		res_d.top_value = sts.empty ? '0 : top_q;
		res_d.is_empty  = sts.empty;
		res_ld          = 1'b0;
		priority if (cmd.take_push) begin
			res_d.overflow = sts.full;
			if (!sts.full) begin
				res_d.top_value = value;
				res_d.is_empty  = 1'b0;
			end
			res_ld = 1'b1;
		end else if (cmd.take_nop) begin
			res_ld = 1'b1;
		end else if (cmd.take_pop && sts.empty) begin
			res_d.underflow = 1'b1;
			res_ld          = 1'b1;
		end else if (cmd.take_srch && sts.empty) begin
			res_ld = 1'b1;
		end else if (cmd.pop_fin) begin
			// count already decremented
			res_d.popped_value = top_q;
			res_d.top_value    = sts.empty ? '0 : rd_data_q;
			res_ld             = 1'b1;
		end else if (cmd.srch_step && (sts.match || sts.last)) begin
			res_d.found    = sts.match;
			res_d.distance = sts.match ? DIST_W'(dist_q) : '0;
			res_ld         = 1'b1;
		end else begin
			res_ld = 1'b0;
		end
	end

endmodule

FILE: test/lss_result_checker_pkg.sv
// Result checker for the LIFO stack with search: keeps its own copy of the
// stack, predicts one result per accepted request and compares rsp fields.
// Depends on lss_pkg.
package lss_result_checker_pkg;
	import lss_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;

	class lss_result_checker;
		logic signed [VAL_W-1:0] words [DEPTH];
		int unsigned depth_used = 0;
		lss_res_t due_q [$];
		int unsigned errors = 0;
		int unsigned n_checked = 0;
		int unsigned n_push = 0, n_over = 0, n_pop = 0, n_under = 0, n_srch = 0, n_hit = 0;
		int unsigned max_dist = 0;

		function void note_request(lss_req_t r);
			lss_res_t want;
			int unsigned d;
			want = '0;
			case (r.kind)
				KIND_PUSH: begin
					n_push++;
					if (depth_used >= DEPTH) begin
						want.overflow = 1'b1;
						n_over++;
					end else begin
						words[depth_used] = r.value;
						depth_used++;
					end
				end
				KIND_POP: begin
					n_pop++;
					if (depth_used == 0) begin
						want.underflow = 1'b1;
						n_under++;
					end else begin
						depth_used--;
						want.popped_value = words[depth_used];
					end
				end
				KIND_SEARCH: begin
					n_srch++;
					for (d = 0; d < depth_used && !want.found; d++) begin
						if (words[depth_used - 1 - d] == r.value) begin
							want.found = 1'b1;
							want.distance = d[DIST_W-1:0];
							n_hit++;
							if (d > max_dist) max_dist = d;
						end
					end
				end
				default: ;
			endcase
			want.top_value = (depth_used == 0) ? '0 : words[depth_used - 1];
			want.is_empty = (depth_used == 0);
			due_q.push_back(want);
		endfunction

		function void flag_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		endfunction

		function void check_result(lss_res_t got);
			lss_res_t want;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = due_q.pop_front();
			n_checked++;
			if (got.popped_value !== want.popped_value)
				flag_field("popped_value", want.popped_value, got.popped_value);
			if (got.underflow !== want.underflow)
				flag_field("underflow", VAL_W'(want.underflow), VAL_W'(got.underflow));
			if (got.overflow !== want.overflow)
				flag_field("overflow", VAL_W'(want.overflow), VAL_W'(got.overflow));
			if (got.found !== want.found)
				flag_field("found", VAL_W'(want.found), VAL_W'(got.found));
			if (got.distance !== want.distance)
				flag_field("distance", VAL_W'(want.distance), VAL_W'(got.distance));
			if (got.top_value !== want.top_value)
				flag_field("top_value", want.top_value, got.top_value);
			if (got.is_empty !== want.is_empty)
				flag_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
		endfunction
	endclass

endpackage

FILE: test/lifo_stack_with_search_tb.sv
// Testbench for lifo_stack_with_search: directed corner requests, then random
// fill/drain runs under several sender idle rates, checked transfer by transfer.
// Depends on lss_pkg, lss_result_checker_pkg and the stack RTL.
module lifo_stack_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lss_pkg::*;
	import lss_result_checker_pkg::*;

	localparam int unsigned MAX_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = DEPTH + 4;
	localparam int unsigned ITEMS_PER_PHASE = 650;
	localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	lss_req_t req;
	logic busy;
	logic done;
	lss_res_t rsp;

	lss_result_checker rsp_chk;
	int unsigned cycles = 0;
	logic signed [VAL_W-1:0] word_pool [8] = '{
		WORD_MAX, WORD_MIN, 32'sh0, 32'shffffffff,
		32'sh1, 32'sh5a5a5a5a, 32'sha5a5a5a5, 32'sh00010000
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lifo_stack_with_search i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("[lifo_stack_with_search] ERROR");
			$finish;
		end else if (arst_n === 1'b1) begin
			if (start && busy === 1'b0) rsp_chk.note_request(req);
			if (done === 1'b1) rsp_chk.check_result(rsp);
		end
	end

	function automatic lss_req_t mk_req(logic [1:0] kind, logic signed [VAL_W-1:0] value);
		lss_req_t r;
		r.kind = kind;
		r.value = value;
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_word();
		if ($urandom_range(9) < 7) return word_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	// filling runs push more than they pop, draining runs the reverse
	function automatic logic [1:0] pick_kind(bit filling);
		int unsigned r;
		r = $urandom_range(99);
		if (r < (filling ? 55 : 20)) return KIND_PUSH;
		if (r < (filling ? 75 : 60)) return KIND_POP;
		if (r < 95) return KIND_SEARCH;
		return KIND_NONE;
	endfunction

	task automatic idle_for(int unsigned pct);
		int unsigned n;
		n = 0;
		while (n < 30 && $urandom_range(99) < pct) n++;
		if (n != 0) begin
			start <= 1'b0;
			req <= mk_req(2'($urandom_range(3)), $urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(lss_req_t r, int unsigned pct);
		idle_for(pct);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin
		int unsigned i, ph, pct, run_left;
		bit filling;
		rsp_chk = new;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		run_left = 0;
		filling = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk_req(KIND_POP, 32'sh0), 0);
		issue(mk_req(KIND_SEARCH, WORD_MAX), 0);
		issue(mk_req(KIND_NONE, 32'shffffffff), 0);
		issue(mk_req(KIND_PUSH, WORD_MIN), 0);
		issue(mk_req(KIND_PUSH, WORD_MAX), 0);
		issue(mk_req(KIND_SEARCH, WORD_MIN), 0);
		issue(mk_req(KIND_SEARCH, 32'sh0), 0);
		issue(mk_req(KIND_PUSH, WORD_MAX), 0);
		issue(mk_req(KIND_SEARCH, WORD_MAX), 0);
		issue(mk_req(KIND_NONE, WORD_MIN), 0);
		issue(mk_req(KIND_POP, 32'sh0), 0);
		for (i = 0; i < DEPTH - 2; i++)
			issue(mk_req(KIND_PUSH, word_pool[(i % 6) + 2]), 0);
		issue(mk_req(KIND_PUSH, 32'sh2a), 0);
		issue(mk_req(KIND_SEARCH, WORD_MIN), 0);
		issue(mk_req(KIND_POP, 32'sh0), 0);

		for (ph = 0; ph < 3; ph++) begin
			pct = (ph == 0) ? 0 : (ph == 1) ? 75 : 7;
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (run_left == 0) begin
					filling = !filling;
					run_left = $urandom_range(20, 60);
				end
				run_left--;
				issue(mk_req(pick_kind(filling), pick_word()), pct);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (rsp_chk.due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transfers checked: %0d push (%0d dropped on full), %0d pop (%0d on empty),",
			rsp_chk.n_checked, rsp_chk.n_push, rsp_chk.n_over, rsp_chk.n_pop, rsp_chk.n_under);
		$display("%0d search (%0d hits, deepest at distance %0d), %0d mismatches",
			rsp_chk.n_srch, rsp_chk.n_hit, rsp_chk.max_dist, rsp_chk.errors);
		if (rsp_chk.errors == 0 && rsp_chk.due_q.size() == 0) begin
			$display("[lifo_stack_with_search] OK");
		end else begin
			$display("[lifo_stack_with_search] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lss_pkg.sv
rtl/core/lss_ctrl.sv
rtl/core/lss_dp.sv
rtl/core/lifo_stack_with_search.sv
test/lss_result_checker_pkg.sv
test/lifo_stack_with_search_tb.sv
